// ===== rtl/pnct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette nearest color table package
// Shared constants, operation codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package pnct_pkg;

    localparam int ENTRIES = 256;
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W = 8;
    localparam int COLOR_W = 32;
    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] NEAREST_LIMIT = DIST_W'(200000);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_FIND    = 2'd2,
        OP_NEAREST = 2'd3
    } op_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic load_out;
    } pnct_cmd_t;

    typedef struct packed {
        logic scan_req;
        logic scan_last;
        logic pipe_empty;
    } pnct_stat_t;

endpackage : pnct_pkg
`default_nettype wire

// ===== rtl/pnct_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette nearest color table controller
// Sequences the handshakes, the table scan, the pipeline drain and the result.
// ----------------------------------------------------------------------------
module pnct_ctrl
    import pnct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire pnct_stat_t stat,
    output pnct_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.scan_req ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : pnct_ctrl
`default_nettype wire

// ===== rtl/pnct_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette nearest color table datapath
// Color memory with entry valid bits, scan counter, distance pipeline, result.
// ----------------------------------------------------------------------------
module pnct_datapath
    import pnct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pnct_cmd_t          cmd,
    output pnct_stat_t              stat,
    input  wire logic [1:0]         opcode,
    input  wire logic [IDX_W-1:0]   index,
    input  wire logic [COLOR_W-1:0] color,
    output logic [COLOR_W-1:0]      read_color,
    output logic                    found,
    output logic [IDX_W-1:0]        found_index,
    output logic                    map_present
);

    logic [COLOR_W-1:0] color_mem [ENTRIES];
    logic [ENTRIES-1:0] entry_valid_reg;
    logic               alloc_reg;

    op_t                item_op_reg;
    logic               item_in_range_reg;
    logic [COLOR_W-1:0] item_color_reg;

    logic [ADDR_W-1:0]  scan_cnt_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    logic               p1_v_reg;
    logic [ADDR_W-1:0]  p1_idx_reg;
    logic               p2_v_reg;
    logic [ADDR_W-1:0]  p2_idx_reg;
    logic               p2_eq_reg;
    logic [15:0]        sq_r_reg;
    logic [15:0]        sq_g_reg;
    logic [15:0]        sq_b_reg;

    logic               exact_hit_reg;
    logic [ADDR_W-1:0]  exact_idx_reg;
    logic               near_hit_reg;
    logic [ADDR_W-1:0]  near_idx_reg;
    logic [DIST_W-1:0]  best_reg;

    logic [COLOR_W-1:0] read_color_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_index_reg;
    logic               map_present_reg;

    op_t                in_op;
    logic               in_range;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COLOR_W-1:0] entry_val;
    logic [7:0]         d_r;
    logic [7:0]         d_g;
    logic [7:0]         d_b;
    logic [DIST_W-1:0]  dist_sum;
    logic [COLOR_W-1:0] res_color;
    logic               res_found;
    logic [ADDR_W-1:0]  res_idx;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign in_op = op_t'(opcode);
    assign in_range = (32'(index) < ENTRIES);
    assign mem_we = cmd.accept && (in_op == OP_WRITE) && in_range;
    assign mem_re = cmd.accept || cmd.scan_step;
    assign rd_addr = cmd.accept ? ADDR_W'(index) : scan_cnt_reg;

    assign stat.scan_req = ((in_op == OP_FIND) || (in_op == OP_NEAREST)) && alloc_reg;
    assign stat.scan_last = (scan_cnt_reg == ADDR_W'(ENTRIES - 1));
    assign stat.pipe_empty = !p1_v_reg && !p2_v_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[ADDR_W'(index)] <= color;
        end
        if (mem_re)
        begin
            rd_data_reg <= color_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            alloc_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                entry_valid_reg[ADDR_W'(index)] <= 1'b1;
            end
            if (cmd.accept && (in_op == OP_WRITE))
            begin
                alloc_reg <= 1'b1;
            end
            if (mem_re)
            begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
        end
    end

    assign entry_val = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_op_reg <= in_op;
            item_in_range_reg <= in_range;
            item_color_reg <= color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            p1_v_reg <= cmd.scan_step;
            p2_v_reg <= p1_v_reg;
        end
    end

    assign d_r = abs_diff(item_color_reg[23:16], entry_val[23:16]);
    assign d_g = abs_diff(item_color_reg[15:8], entry_val[15:8]);
    assign d_b = abs_diff(item_color_reg[7:0], entry_val[7:0]);

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= scan_cnt_reg;
        p2_idx_reg <= p1_idx_reg;
        p2_eq_reg <= (entry_val == item_color_reg);
        sq_r_reg <= d_r * d_r;
        sq_g_reg <= d_g * d_g;
        sq_b_reg <= d_b * d_b;
    end

    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_hit_reg <= 1'b0;
            near_hit_reg <= 1'b0;
            best_reg <= NEAREST_LIMIT;
        end
        else if (cmd.accept)
        begin
            exact_hit_reg <= 1'b0;
            near_hit_reg <= 1'b0;
            best_reg <= NEAREST_LIMIT;
        end
        else if (p2_v_reg)
        begin
            if (p2_eq_reg && !exact_hit_reg)
            begin
                exact_hit_reg <= 1'b1;
            end
            if (dist_sum < best_reg)
            begin
                near_hit_reg <= 1'b1;
                best_reg <= dist_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_v_reg && p2_eq_reg && !exact_hit_reg)
        begin
            exact_idx_reg <= p2_idx_reg;
        end
        if (p2_v_reg && (dist_sum < best_reg))
        begin
            near_idx_reg <= p2_idx_reg;
        end
    end

    always_comb
    begin
        res_color = '0;
        res_found = 1'b0;
        res_idx = '0;
        unique case (item_op_reg)
            OP_WRITE:
            begin
                res_found = 1'b0;
            end
            OP_READ:
            begin
                if (alloc_reg && item_in_range_reg)
                begin
                    res_color = entry_val;
                end
            end
            OP_FIND:
            begin
                res_found = exact_hit_reg;
                res_idx = exact_hit_reg ? exact_idx_reg : '0;
            end
            OP_NEAREST:
            begin
                res_found = exact_hit_reg || near_hit_reg;
                if (exact_hit_reg)
                begin
                    res_idx = exact_idx_reg;
                end
                else if (near_hit_reg)
                begin
                    res_idx = near_idx_reg;
                end
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_color_reg <= res_color;
            found_reg <= res_found;
            found_index_reg <= IDX_W'(res_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_present_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            map_present_reg <= alloc_reg;
        end
    end

    assign read_color = read_color_reg;
    assign found = found_reg;
    assign found_index = found_index_reg;
    assign map_present = map_present_reg;

`ifndef SYNTHESIS
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.pipe_empty)
        else $error("Result loaded while the scan pipeline still holds entries.");

    a_scan_needs_map: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> alloc_reg)
        else $error("Table scan issued while the map is absent.");

    a_exact_is_near: assert property (@(posedge clk) disable iff (!rst_n)
        exact_hit_reg |-> near_hit_reg)
        else $error("Exact match recorded without a nearest candidate.");

    a_nearest_finds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && (item_op_reg == OP_NEAREST) && alloc_reg) |=> found_reg)
        else $error("Nearest search on a present map returned no index.");
`endif

endmodule : pnct_datapath
`default_nettype wire

// ===== rtl/palette_nearest_color_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette nearest color table unit
// Palette of ARGB colors with write, read, exact find and nearest RGB search.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Word
//  input     in_valid / in_ready   opcode, index, color
//  output    out_valid / out_ready read_color, found, found_index, map_present
//
// A write or read word goes from acceptance straight to the finish state, where
// its result is loaded once the output is free and the unit returns to idle.
// A find or nearest word on a present map first scans the color memory through
// its single read port, one entry per cycle, then drains the distance pipeline
// and loads its result in the finish state before the next word is accepted.
// Entry valid bits clear at reset at once, so no clearing pass is needed.
// A new word is accepted while an earlier result still waits on out_ready.
// ----------------------------------------------------------------------------
module palette_nearest_color_table_unit
    import pnct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [IDX_W-1:0]   index,
    input  wire logic [COLOR_W-1:0] color,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COLOR_W-1:0]      read_color,
    output logic                    found,
    output logic [IDX_W-1:0]        found_index,
    output logic                    map_present
);

    pnct_cmd_t  cmd;
    pnct_stat_t stat;

    pnct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pnct_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .index       (index),
        .color       (color),
        .read_color  (read_color),
        .found       (found),
        .found_index (found_index),
        .map_present (map_present)
    );

endmodule : palette_nearest_color_table_unit
`default_nettype wire
